// File: rtl/nms3_pkg.sv
// Shared types, sizes and helpers for the 3D axis-aligned box suppression block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package nms3_pkg;

    localparam int MaxBoxes  = 64;
    localparam int IdxW      = $clog2(MaxBoxes);
    localparam int CntW      = $clog2(MaxBoxes + 1);
    localparam int FieldW    = 16;
    localparam int CoordBits = 16;
    localparam int ExtW      = CoordBits;
    localparam int VolW      = 3 * ExtW;
    localparam int LimW      = 17;
    localparam int ScaleBits = 16;
    localparam int UniW      = VolW + 1;
    localparam int UniLoW    = (UniW + 1) / 2;
    localparam int UniHiW    = UniW - UniLoW;
    localparam int RhsW      = UniW + LimW;
    localparam int LhsW      = VolW + ScaleBits;
    localparam int QDepth    = 4;
    localparam int QPtrW     = $clog2(QDepth);
    localparam int OutIdxW   = 6;

    typedef struct packed {
        logic [FieldW-1:0] lo_x;
        logic [FieldW-1:0] lo_y;
        logic [FieldW-1:0] lo_z;
        logic [FieldW-1:0] hi_x;
        logic [FieldW-1:0] hi_y;
        logic [FieldW-1:0] hi_z;
        logic [FieldW-1:0] score;
        logic              store;
        logic              last;
        logic              ovf;
    } t_box_ent;

    function automatic logic signed [CoordBits-1:0] coord_of(input logic [FieldW-1:0] raw);
        return $signed(raw[CoordBits-1:0]);
    endfunction

    function automatic logic [ExtW-1:0] ext_of(input logic signed [CoordBits-1:0] lo,
                                               input logic signed [CoordBits-1:0] hi);
        logic signed [CoordBits:0] d;
        d = {hi[CoordBits-1], hi} - {lo[CoordBits-1], lo};
        return (d > 0) ? d[ExtW-1:0] : '0;
    endfunction

endpackage

// File: rtl/nms3_front.sv
// Input side: takes box transfers, counts the batch and marks dropped boxes.
// Depends on nms3_pkg.
`timescale 1ns / 1ps
module nms3_front
    import nms3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FieldW-1:0] i_min_x,
    input  logic [FieldW-1:0] i_min_y,
    input  logic [FieldW-1:0] i_min_z,
    input  logic [FieldW-1:0] i_max_x,
    input  logic [FieldW-1:0] i_max_y,
    input  logic [FieldW-1:0] i_max_z,
    input  logic [FieldW-1:0] i_box_score,
    input  logic              i_last_box,
    input  logic              i_full,
    output logic              o_push,
    output t_box_ent          o_ent
);

    logic [CntW-1:0] r_cnt;
    logic            r_ovf;
    logic            accept;
    logic            store;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign store      = (r_cnt != CntW'(MaxBoxes));
    assign o_push     = accept && (store || i_last_box);

    always_comb begin
        o_ent.lo_x  = i_min_x;
        o_ent.lo_y  = i_min_y;
        o_ent.lo_z  = i_min_z;
        o_ent.hi_x  = i_max_x;
        o_ent.hi_y  = i_max_y;
        o_ent.hi_z  = i_max_z;
        o_ent.score = i_box_score;
        o_ent.store = store;
        o_ent.last  = i_last_box;
        o_ent.ovf   = r_ovf || !store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (i_last_box) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                if (store) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_ovf <= r_ovf || !store;
            end
        end
    end

endmodule

// File: rtl/nms3_queue.sv
// Short queue of box entries between the input side and the processing side.
// Depends on nms3_pkg.
`timescale 1ns / 1ps
module nms3_queue
    import nms3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_box_ent i_ent,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_vld,
    output t_box_ent o_head
);

    t_box_ent         r_mem [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QPtrW:0]   r_cnt;

    assign o_full = (r_cnt == (QPtrW + 1)'(QDepth));
    assign o_vld  = (r_cnt != '0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/nms3_back.sv
// Processing side: stores boxes and volumes, ranks by score, runs the pairwise
// overlap pipeline and sends kept indices out. Depends on nms3_pkg.
`timescale 1ns / 1ps
module nms3_back
    import nms3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_vld,
    input  t_box_ent           i_q_ent,
    output logic               o_q_pop,
    input  logic [LimW-1:0]    i_limit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OutIdxW-1:0] o_kept_index,
    output logic               o_last_kept,
    output logic               o_overflow
);

    typedef enum logic [3:0] {
        S_LOAD, S_VOL1, S_VOL2, S_RK_A, S_RK_AW, S_RK_SCAN, S_RK_WR,
        S_OA, S_OI, S_OBOX, S_EMIT, S_INNER, S_DRAIN, S_FLUSH
    } t_state;

    t_state r_state;

    logic [3*CoordBits-1:0] r_lo_mem [MaxBoxes];
    logic [3*CoordBits-1:0] r_hi_mem [MaxBoxes];
    logic [VolW-1:0]        r_vol_mem [MaxBoxes];
    logic [FieldW-1:0]      r_score_mem [MaxBoxes];
    logic [IdxW-1:0]        r_rank_mem [MaxBoxes];

    logic [3*CoordBits-1:0] r_lo_q, r_hi_q;
    logic [VolW-1:0]        r_vol_q;
    logic signed [FieldW-1:0] r_score_q;
    logic [IdxW-1:0]        r_rank_q;

    logic [CntW-1:0] r_n, r_a, r_b;
    logic [IdxW-1:0] r_rk_cnt, r_scan_idx, r_i, r_pend_idx;
    logic            r_scan_vld, r_last, r_ovf, r_pend_vld;
    logic signed [FieldW-1:0] r_sa;
    logic [ExtW-1:0]   r_ex, r_ey, r_ez;
    logic [2*ExtW-1:0] r_pxy;
    logic [3*CoordBits-1:0] r_ilo, r_ihi;
    logic [VolW-1:0]   r_ivol;
    logic [MaxBoxes-1:0] r_supp;
    logic              r_out_valid, r_out_last, r_out_ovf;
    logic [IdxW-1:0]   r_out_idx;

    logic            box_we, vol_we, rank_we, slot_free, issue, pipe_busy, sc_gt;
    logic            emit_go;
    logic [IdxW-1:0] score_raddr, rank_raddr;
    logic [VolW-1:0] vol_wd;
    logic [3*CoordBits-1:0] ent_lo, ent_hi;

    // Pair pipeline registers.
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic [IdxW-1:0]      r_j2, r_j3, r_j4, r_j5, r_j6, r_j7;
    logic [ExtW-1:0]      r_e0, r_e1, r_e2, r_e2_4;
    logic [2*ExtW-1:0]    r_p01;
    logic [VolW-1:0]      r_vj3, r_vj4, r_vj5, r_inter5, r_inter6, r_inter7;
    logic [UniW-1:0]      r_uni6;
    logic [UniLoW+LimW-1:0] r_plo7;
    logic [UniHiW+LimW-1:0] r_phi7;
    logic [ExtW-1:0]      ie [3];
    logic [RhsW-1:0]      rhs;
    logic [RhsW-1:0]      lhs;

    assign ent_lo = {coord_of(i_q_ent.lo_x), coord_of(i_q_ent.lo_y), coord_of(i_q_ent.lo_z)};
    assign ent_hi = {coord_of(i_q_ent.hi_x), coord_of(i_q_ent.hi_y), coord_of(i_q_ent.hi_z)};

    assign o_q_pop     = (r_state == S_LOAD) && i_q_vld;
    assign box_we      = o_q_pop && i_q_ent.store;
    assign vol_we      = (r_state == S_VOL2);
    assign vol_wd      = r_pxy * r_ez;
    assign rank_we     = (r_state == S_RK_WR);
    assign score_raddr = (r_state == S_RK_A) ? r_a[IdxW-1:0] : r_b[IdxW-1:0];
    assign rank_raddr  = (r_state == S_OA) ? r_a[IdxW-1:0] : r_b[IdxW-1:0];
    assign slot_free   = !r_out_valid || i_out_ready;
    assign emit_go     = ((r_state == S_EMIT) || (r_state == S_FLUSH)) && slot_free;
    assign issue       = (r_state == S_INNER) && (r_b < r_n);
    assign pipe_busy   = r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_v6 || r_v7;
    assign sc_gt       = (r_score_q > r_sa) ||
                         ((r_score_q == r_sa) && (r_scan_idx < r_a[IdxW-1:0]));

    assign o_out_valid  = r_out_valid;
    assign o_kept_index = OutIdxW'(r_out_idx);
    assign o_last_kept  = r_out_last;
    assign o_overflow   = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (box_we) begin
            r_lo_mem[r_n[IdxW-1:0]]    <= ent_lo;
            r_hi_mem[r_n[IdxW-1:0]]    <= ent_hi;
            r_score_mem[r_n[IdxW-1:0]] <= i_q_ent.score;
        end
        r_lo_q    <= r_lo_mem[r_rank_q];
        r_hi_q    <= r_hi_mem[r_rank_q];
        r_score_q <= $signed(r_score_mem[score_raddr]);
    end

    always_ff @(posedge i_clk) begin
        if (vol_we) begin
            r_vol_mem[r_n[IdxW-1:0]] <= vol_wd;
        end
        r_vol_q <= r_vol_mem[r_rank_q];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[r_rk_cnt] <= r_a[IdxW-1:0];
        end
        r_rank_q <= r_rank_mem[rank_raddr];
    end

    always_comb begin
        logic signed [CoordBits-1:0] li, lj, hi, hj, ml, mh;
        for (int k = 0; k < 3; k++) begin
            li = $signed(r_ilo[k*CoordBits +: CoordBits]);
            lj = $signed(r_lo_q[k*CoordBits +: CoordBits]);
            hi = $signed(r_ihi[k*CoordBits +: CoordBits]);
            hj = $signed(r_hi_q[k*CoordBits +: CoordBits]);
            ml = (li > lj) ? li : lj;
            mh = (hi < hj) ? hi : hj;
            ie[k] = ext_of(ml, mh);
        end
    end

    assign rhs = RhsW'(r_plo7) + (RhsW'(r_phi7) << UniLoW);
    assign lhs = RhsW'({r_inter7, {ScaleBits{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_j2     <= r_rank_q;
        r_j3     <= r_j2;
        r_e0     <= ie[0];
        r_e1     <= ie[1];
        r_e2     <= ie[2];
        r_vj3    <= r_vol_q;
        r_j4     <= r_j3;
        r_p01    <= r_e0 * r_e1;
        r_e2_4   <= r_e2;
        r_vj4    <= r_vj3;
        r_j5     <= r_j4;
        r_inter5 <= r_p01 * r_e2_4;
        r_vj5    <= r_vj4;
        r_j6     <= r_j5;
        r_uni6   <= UniW'(r_ivol) + UniW'(r_vj5) - UniW'(r_inter5);
        r_inter6 <= r_inter5;
        r_j7     <= r_j6;
        r_plo7   <= r_uni6[UniLoW-1:0] * i_limit;
        r_phi7   <= r_uni6[UniW-1:UniLoW] * i_limit;
        r_inter7 <= r_inter6;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_rk_cnt    <= '0;
            r_scan_vld  <= 1'b0;
            r_last      <= 1'b0;
            r_ovf       <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_supp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && !emit_go) begin
                r_out_valid <= 1'b0;
            end
            if (r_v7 && (lhs > rhs)) begin
                r_supp[r_j7] <= 1'b1;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_q_vld) begin
                        r_last <= i_q_ent.last;
                        r_ovf  <= i_q_ent.ovf;
                        r_ex   <= ext_of(coord_of(i_q_ent.lo_x), coord_of(i_q_ent.hi_x));
                        r_ey   <= ext_of(coord_of(i_q_ent.lo_y), coord_of(i_q_ent.hi_y));
                        r_ez   <= ext_of(coord_of(i_q_ent.lo_z), coord_of(i_q_ent.hi_z));
                        if (i_q_ent.store) begin
                            r_state <= S_VOL1;
                        end else begin
                            r_a     <= '0;
                            r_state <= S_RK_A;
                        end
                    end
                end
                S_VOL1: begin
                    r_pxy   <= r_ex * r_ey;
                    r_state <= S_VOL2;
                end
                S_VOL2: begin
                    r_n <= r_n + 1'b1;
                    if (r_last) begin
                        r_a     <= '0;
                        r_state <= S_RK_A;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_RK_A: begin
                    r_b     <= '0;
                    r_state <= S_RK_AW;
                end
                S_RK_AW: begin
                    r_sa       <= r_score_q;
                    r_rk_cnt   <= '0;
                    r_scan_vld <= 1'b1;
                    r_scan_idx <= r_b[IdxW-1:0];
                    r_b        <= r_b + 1'b1;
                    r_state    <= S_RK_SCAN;
                end
                S_RK_SCAN: begin
                    if (r_scan_vld && sc_gt) begin
                        r_rk_cnt <= r_rk_cnt + 1'b1;
                    end
                    if (r_b < r_n) begin
                        r_scan_vld <= 1'b1;
                        r_scan_idx <= r_b[IdxW-1:0];
                        r_b        <= r_b + 1'b1;
                    end else begin
                        r_scan_vld <= 1'b0;
                        if (!r_scan_vld) begin
                            r_state <= S_RK_WR;
                        end
                    end
                end
                S_RK_WR: begin
                    if (CntW'(r_a + 1'b1) == r_n) begin
                        r_a     <= '0;
                        r_state <= S_OA;
                    end else begin
                        r_a     <= r_a + 1'b1;
                        r_state <= S_RK_A;
                    end
                end
                S_OA: begin
                    r_state <= S_OI;
                end
                S_OI: begin
                    r_i <= r_rank_q;
                    if (r_supp[r_rank_q]) begin
                        r_a <= r_a + 1'b1;
                        if (CntW'(r_a + 1'b1) == r_n) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_OA;
                        end
                    end else begin
                        r_state <= S_OBOX;
                    end
                end
                S_OBOX: begin
                    r_ilo  <= r_lo_q;
                    r_ihi  <= r_hi_q;
                    r_ivol <= r_vol_q;
                    if (r_pend_vld) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_pend_vld <= 1'b1;
                        r_pend_idx <= r_i;
                        r_b        <= r_a + 1'b1;
                        r_state    <= S_INNER;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_pend_idx;
                        r_out_last  <= 1'b0;
                        r_out_ovf   <= r_ovf;
                        r_pend_idx  <= r_i;
                        r_b         <= r_a + 1'b1;
                        r_state     <= S_INNER;
                    end
                end
                S_INNER: begin
                    if (r_b < r_n) begin
                        r_b <= r_b + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        r_a <= r_a + 1'b1;
                        if (CntW'(r_a + 1'b1) == r_n) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_OA;
                        end
                    end
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_pend_idx;
                        r_out_last  <= 1'b1;
                        r_out_ovf   <= r_ovf;
                        r_pend_vld  <= 1'b0;
                        r_supp      <= '0;
                        r_n         <= '0;
                        r_ovf       <= 1'b0;
                        r_last      <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// File: rtl/nms_3d_axis_aligned.sv
// Top level of the 3D axis-aligned box suppression block: threshold register,
// input side, entry queue and processing side. Depends on nms3_pkg and submodules.
//
//   channel   direction  handshake                 payload
//   in        in         i_in_valid / o_in_ready   i_min_*, i_max_*, i_box_score, i_last_box
//   out       out        o_out_valid / i_out_ready o_kept_index, o_last_kept, o_overflow
//   cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data (IoU limit, Q1.16)
//
// A box is stored in S_LOAD, then S_VOL1 and S_VOL2 run the two-step volume multiply.
// After the last box, ranking scans every stored score on the single score memory port,
// and each kept box runs its search over the lower-ranked boxes in the pair pipeline.
// Synchronous active-low reset; no clearing pass. The four-entry queue keeps
// taking boxes while processing runs, and a stalled output holds the pair search.
`timescale 1ns / 1ps
module nms_3d_axis_aligned
    import nms3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FieldW-1:0]  i_min_x,
    input  logic [FieldW-1:0]  i_min_y,
    input  logic [FieldW-1:0]  i_min_z,
    input  logic [FieldW-1:0]  i_max_x,
    input  logic [FieldW-1:0]  i_max_y,
    input  logic [FieldW-1:0]  i_max_z,
    input  logic [FieldW-1:0]  i_box_score,
    input  logic               i_last_box,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OutIdxW-1:0] o_kept_index,
    output logic               o_last_kept,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LimW-1:0]    i_cfg_data
);

    logic [LimW-1:0] r_iou_limit;
    logic            push, full, pop, q_vld;
    t_box_ent        ent, head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_limit <= LimW'(32768);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_iou_limit <= i_cfg_data;
        end
    end

    nms3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_min_x     (i_min_x),
        .i_min_y     (i_min_y),
        .i_min_z     (i_min_z),
        .i_max_x     (i_max_x),
        .i_max_y     (i_max_y),
        .i_max_z     (i_max_z),
        .i_box_score (i_box_score),
        .i_last_box  (i_last_box),
        .i_full      (full),
        .o_push      (push),
        .o_ent       (ent)
    );

    nms3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (ent),
        .o_full  (full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_head  (head)
    );

    nms3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_vld      (q_vld),
        .i_q_ent      (head),
        .o_q_pop      (pop),
        .i_limit      (r_iou_limit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kept_index (o_kept_index),
        .o_last_kept  (o_last_kept),
        .o_overflow   (o_overflow)
    );

endmodule
